### rtl/gcbc_pkg.sv
// ----------------------------------------------------------------------------
// Grid cell border classifier package
// Shared constants, the stored cell layout, the cell store port bundle and
// the sequencer state type.
// ----------------------------------------------------------------------------
package gcbc_pkg;

   localparam int MAX_ROWS   = 32;
   localparam int MAX_COLS   = 32;
   localparam int COLOR_BITS = 4;

   localparam int ROW_BITS   = 5;
   localparam int COL_BITS   = 5;
   localparam int CFG_BITS   = 6;
   localparam int CRD_BITS   = CFG_BITS + 1;

   localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;
   localparam int ADDR_BITS  = $clog2(CELL_COUNT);

   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRID_COLS = 1'd1;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam int STEP_BITS = 4;
   localparam logic [STEP_BITS-1:0] STEP_CENTER = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_CAPTURE = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_LAST_READ = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_LAST = 4'd9;

   // Neighbor offsets in grid order: left, up-left, up, up-right, right,
   // down-right, down, down-left.
   localparam logic signed [1:0] NB_DY [8] = '{2'sd0, -2'sd1, -2'sd1, -2'sd1,
                                               2'sd0, 2'sd1, 2'sd1, 2'sd1};
   localparam logic signed [1:0] NB_DX [8] = '{-2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                               2'sd1, 2'sd1, 2'sd0, -2'sd1};

   typedef struct packed {
      logic                  visible;
      logic [COLOR_BITS-1:0] back_color;
      logic [COLOR_BITS-1:0] front_color;
   } cell_type;

   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [ADDR_BITS-1:0] addr;
      cell_type             wdata;
   } mem_req_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DONE
   } state_type;

endpackage

### rtl/gcbc_cell_store.sv
// ----------------------------------------------------------------------------
// Grid cell store
// Single-port cell memory with a registered read port.
// ----------------------------------------------------------------------------
module gcbc_cell_store (
   input  logic                  clock,
   input  gcbc_pkg::mem_req_type mem_req,
   output gcbc_pkg::cell_type    rd_data
);

   gcbc_pkg::cell_type store_ff [gcbc_pkg::CELL_COUNT];
   gcbc_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= store_ff[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/grid_cell_border_classifier_core.sv
// ----------------------------------------------------------------------------
// Grid cell border classifier core
// Stores a grid of two-faced colored cells and reports, for one queried cell,
// the border and inner corner bits of its front and mirrored back face.
// ----------------------------------------------------------------------------
// Usage: the req channel carries one beat per item. A write beat stores one
// cell and gives no response. A query beat gives exactly one rsp beat. A
// query outside the configured size answers with outside set, by way of the
// result state and the rsp register; a query inside reads the center and its
// eight neighbors through the single memory port, one per cycle, before the
// response is loaded into the rsp register. req_ready stays low while a
// query is in progress. A finished response waits in the rsp register while
// the receiver stalls; the core returns to idle only once that register is
// free, so writes may be taken meanwhile. After reset the store is swept to
// invisible cells, one cell per cycle, over all 1024 cells with req_ready
// low; grid_rows and grid_cols reset to 32. The csr port may be written at
// any time but is meant to change only while the core is idle.
// ----------------------------------------------------------------------------
module grid_cell_border_classifier_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_kind,
   input  logic [gcbc_pkg::ROW_BITS-1:0]         req_row,
   input  logic [gcbc_pkg::COL_BITS-1:0]         req_col,
   input  logic [gcbc_pkg::COLOR_BITS-1:0]       req_front_color,
   input  logic [gcbc_pkg::COLOR_BITS-1:0]       req_back_color,
   input  logic                                  req_visible,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [3:0]                            rsp_front_border,
   output logic [3:0]                            rsp_front_corner,
   output logic [3:0]                            rsp_back_border,
   output logic [3:0]                            rsp_back_corner,
   output logic                                  rsp_outside,
   input  logic                                  csr_we,
   input  logic [gcbc_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [gcbc_pkg::CFG_BITS-1:0]         csr_wdata
);

   localparam logic [gcbc_pkg::CFG_BITS-1:0] ROWS_CAP = gcbc_pkg::CFG_BITS'(gcbc_pkg::MAX_ROWS);
   localparam logic [gcbc_pkg::CFG_BITS-1:0] COLS_CAP = gcbc_pkg::CFG_BITS'(gcbc_pkg::MAX_COLS);
   localparam logic [gcbc_pkg::ADDR_BITS-1:0] CLEAR_LAST =
      gcbc_pkg::ADDR_BITS'(gcbc_pkg::CELL_COUNT - 1);

   gcbc_pkg::state_type state_ff, state_in;
   logic [gcbc_pkg::CFG_BITS-1:0] grid_rows_ff, grid_cols_ff;
   logic [gcbc_pkg::ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [gcbc_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic [gcbc_pkg::ROW_BITS-1:0] row_ff, row_in;
   logic [gcbc_pkg::COL_BITS-1:0] col_ff, col_in;
   logic outside_ff, outside_in;
   logic ok_ff, ok_in;
   gcbc_pkg::cell_type center_ff, center_in;
   logic [7:0] fm_ff, fm_in;
   logic [7:0] bm_ff, bm_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] front_border_ff, front_border_in;
   logic [3:0] front_corner_ff, front_corner_in;
   logic [3:0] back_border_ff, back_border_in;
   logic [3:0] back_corner_ff, back_corner_in;
   logic rsp_outside_ff, rsp_outside_in;

   gcbc_pkg::mem_req_type mem_req;
   gcbc_pkg::cell_type rd_data;

   logic [gcbc_pkg::CFG_BITS-1:0] rows_eff, cols_eff;
   logic req_fire, req_out_of_size, req_in_store, rsp_load;
   logic [2:0] issue_idx, recv_idx;
   logic signed [gcbc_pkg::CRD_BITS-1:0] nb_y, nb_x;
   logic nb_ok;
   logic [gcbc_pkg::ADDR_BITS-1:0] nb_addr, center_addr, req_addr;
   logic [7:0] front_bits, back_bits;

   function automatic logic [7:0] classify(input logic l, input logic lt, input logic t,
                                           input logic tr, input logic r, input logic rb,
                                           input logic b, input logic bl);
      logic [3:0] border;
      logic [3:0] corner;
      border = {!b, !r, !t, !l};
      corner = {b && l && !bl, r && b && !rb, t && r && !tr, l && t && !lt};
      return {corner, border};
   endfunction

   gcbc_cell_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rows_eff = (grid_rows_ff > ROWS_CAP) ? ROWS_CAP : grid_rows_ff;
   assign cols_eff = (grid_cols_ff > COLS_CAP) ? COLS_CAP : grid_cols_ff;

   assign req_ready = (state_ff == gcbc_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_out_of_size = (gcbc_pkg::CFG_BITS'(req_row) >= rows_eff) ||
                            (gcbc_pkg::CFG_BITS'(req_col) >= cols_eff);
   assign req_in_store = (32'(req_row) < gcbc_pkg::MAX_ROWS) &&
                         (32'(req_col) < gcbc_pkg::MAX_COLS);
   assign req_addr = gcbc_pkg::ADDR_BITS'(req_row) * gcbc_pkg::ADDR_BITS'(gcbc_pkg::MAX_COLS) +
                     gcbc_pkg::ADDR_BITS'(req_col);
   assign center_addr = gcbc_pkg::ADDR_BITS'(row_ff) *
                        gcbc_pkg::ADDR_BITS'(gcbc_pkg::MAX_COLS) +
                        gcbc_pkg::ADDR_BITS'(col_ff);

   assign rsp_load = (state_ff == gcbc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Neighbor issued in this step and neighbor whose data returns in it.
   assign issue_idx = 3'(step_ff - 4'd1);
   assign recv_idx  = 3'(step_ff - 4'd2);

   assign nb_y = $signed(gcbc_pkg::CRD_BITS'(row_ff)) +
                 gcbc_pkg::CRD_BITS'(gcbc_pkg::NB_DY[issue_idx]);
   assign nb_x = $signed(gcbc_pkg::CRD_BITS'(col_ff)) +
                 gcbc_pkg::CRD_BITS'(gcbc_pkg::NB_DX[issue_idx]);
   assign nb_ok = (nb_y >= 0) && (nb_x >= 0) &&
                  (nb_y < $signed({1'b0, rows_eff})) &&
                  (nb_x < $signed({1'b0, cols_eff}));
   assign nb_addr = gcbc_pkg::ADDR_BITS'(nb_y[gcbc_pkg::ROW_BITS-1:0]) *
                    gcbc_pkg::ADDR_BITS'(gcbc_pkg::MAX_COLS) +
                    gcbc_pkg::ADDR_BITS'(nb_x[gcbc_pkg::COL_BITS-1:0]);

   // The back face swaps left and right neighbors.
   assign front_bits = classify(fm_ff[0], fm_ff[1], fm_ff[2], fm_ff[3],
                                fm_ff[4], fm_ff[5], fm_ff[6], fm_ff[7]);
   assign back_bits  = classify(bm_ff[4], bm_ff[3], bm_ff[2], bm_ff[1],
                                bm_ff[0], bm_ff[7], bm_ff[6], bm_ff[5]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcbc_pkg::ST_CLEAR: begin
            if (clr_addr_ff == CLEAR_LAST) begin
               state_in = gcbc_pkg::ST_IDLE;
            end
         end
         gcbc_pkg::ST_IDLE: begin
            if (req_fire && (req_kind == gcbc_pkg::KIND_QUERY)) begin
               state_in = req_out_of_size ? gcbc_pkg::ST_DONE : gcbc_pkg::ST_FETCH;
            end
         end
         gcbc_pkg::ST_FETCH: begin
            if (step_ff == gcbc_pkg::STEP_LAST) begin
               state_in = gcbc_pkg::ST_DONE;
            end
         end
         gcbc_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = gcbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gcbc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mem_req         = '0;
      clr_addr_in     = clr_addr_ff;
      step_in         = step_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      outside_in      = outside_ff;
      ok_in           = ok_ff;
      center_in       = center_ff;
      fm_in           = fm_ff;
      bm_in           = bm_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      front_border_in = front_border_ff;
      front_corner_in = front_corner_ff;
      back_border_in  = back_border_ff;
      back_corner_in  = back_corner_ff;
      rsp_outside_in  = rsp_outside_ff;
      case (state_ff)
         gcbc_pkg::ST_CLEAR: begin
            mem_req.we   = 1'b1;
            mem_req.addr = clr_addr_ff;
            clr_addr_in  = clr_addr_ff + 1'b1;
         end
         gcbc_pkg::ST_IDLE: begin
            if (req_fire && (req_kind == gcbc_pkg::KIND_WRITE)) begin
               mem_req.we                = req_in_store;
               mem_req.addr              = req_addr;
               mem_req.wdata.visible     = req_visible;
               mem_req.wdata.back_color  = req_back_color;
               mem_req.wdata.front_color = req_front_color;
            end else if (req_fire) begin
               row_in     = req_row;
               col_in     = req_col;
               outside_in = req_out_of_size;
               step_in    = gcbc_pkg::STEP_CENTER;
               fm_in      = '0;
               bm_in      = '0;
            end
         end
         gcbc_pkg::ST_FETCH: begin
            step_in = step_ff + 1'b1;
            if (step_ff <= gcbc_pkg::STEP_LAST_READ) begin
               mem_req.re = 1'b1;
               if (step_ff == gcbc_pkg::STEP_CENTER) begin
                  mem_req.addr = center_addr;
                  ok_in        = 1'b1;
               end else begin
                  mem_req.addr = nb_addr;
                  ok_in        = nb_ok;
               end
            end
            if (step_ff == gcbc_pkg::STEP_CAPTURE) begin
               center_in = rd_data;
            end else if (step_ff > gcbc_pkg::STEP_CAPTURE) begin
               fm_in[recv_idx] = ok_ff && rd_data.visible &&
                                 (rd_data.front_color == center_ff.front_color);
               bm_in[recv_idx] = ok_ff && rd_data.visible &&
                                 (rd_data.back_color == center_ff.back_color);
            end
         end
         gcbc_pkg::ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in    = 1'b1;
               rsp_outside_in  = outside_ff;
               front_border_in = outside_ff ? 4'd0 : front_bits[3:0];
               front_corner_in = outside_ff ? 4'd0 : front_bits[7:4];
               back_border_in  = outside_ff ? 4'd0 : back_bits[3:0];
               back_corner_in  = outside_ff ? 4'd0 : back_bits[7:4];
            end
         end
         default: begin
            mem_req = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcbc_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         grid_rows_ff <= ROWS_CAP;
         grid_cols_ff <= COLS_CAP;
         step_ff      <= gcbc_pkg::STEP_CENTER;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         if (csr_we && (csr_index == gcbc_pkg::CSR_GRID_ROWS)) begin
            grid_rows_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == gcbc_pkg::CSR_GRID_COLS)) begin
            grid_cols_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff          <= row_in;
      col_ff          <= col_in;
      outside_ff      <= outside_in;
      ok_ff           <= ok_in;
      center_ff       <= center_in;
      fm_ff           <= fm_in;
      bm_ff           <= bm_in;
      front_border_ff <= front_border_in;
      front_corner_ff <= front_corner_in;
      back_border_ff  <= back_border_in;
      back_corner_ff  <= back_corner_in;
      rsp_outside_ff  <= rsp_outside_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_front_border = front_border_ff;
   assign rsp_front_corner = front_corner_ff;
   assign rsp_back_border  = back_border_ff;
   assign rsp_back_corner  = back_corner_ff;
   assign rsp_outside      = rsp_outside_ff;

   // A write beat never produces a response.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_kind == gcbc_pkg::KIND_WRITE)) |=> !$rose(rsp_valid))
      else $error("response raised after a write beat");

   // Responses only come out of the result state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == gcbc_pkg::ST_DONE))
      else $error("response raised outside the result state");

   // An outside response carries no border or corner bits.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outside) |-> ((rsp_front_border == 4'd0) &&
         (rsp_front_corner == 4'd0) && (rsp_back_border == 4'd0) &&
         (rsp_back_corner == 4'd0)))
      else $error("outside response with nonzero bits");

endmodule
